[src/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffba_pkg;
    localparam int MAX_PAGES    = 64;
    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 12;
    localparam int ARENA_BYTES  = MAX_PAGES * PAGE_BYTES;
    localparam int AW           = 18;
    localparam int HW           = 16;
    localparam int PW           = 7;

    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_FAIL  = 2'd1;
    localparam logic [1:0] ST_FREE  = 2'd2;
    localparam logic       RT_ALLOC = 1'b0;

    typedef struct packed {
        logic          req_type;
        logic [AW-1:0] request_size;
        logic [AW-1:0] block_address;
        logic          address_is_null;
    } t_req;

    typedef struct packed {
        logic [AW-1:0] result_address;
        logic [1:0]    status;
    } t_rsp;

    // size, free flag, link flag, next offset
    typedef struct packed {
        logic [AW-1:0] size;
        logic          free;
        logic          link;
        logic [AW-1:0] next;
    } t_hdr;
endpackage
`default_nettype wire

[src/first_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator with page growth and coalescing on free.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_stall carries one request transaction: an
// allocate or a free. Output channel o_valid/i_stall carries exactly one
// response per request, in order. One request is handled at a time; the
// input stalls from acceptance until the response has been taken.
// Steps: an allocate walks the chain, reading each header and then
// deciding on it; a fit with room to spare is split and its tail header
// written, and when nothing fits a page is appended and then walked. A
// free reads and marks the block, merges each free successor, then walks
// the chain from the head to find a free predecessor and merge into it.
// The header memory has a registered read port.
// Reset clears the chain, the page count and sets page_limit to 64; the
// header memory is not cleared, headers are written before they are read.
// When the receiver stalls, the response is held and no new request is
// taken until it leaves.
// i_cfg_we writes page_limit; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_block_allocator import ffba_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [6:0]  i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_req        i_req,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_rsp             o_rsp
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_ARD   = 10'b0000000010,
        S_AEV   = 10'b0000000100,
        S_GROW  = 10'b0000001000,
        S_FRD   = 10'b0000010000,
        S_FEV   = 10'b0000100000,
        S_PRD   = 10'b0001000000,
        S_PEV   = 10'b0010000000,
        S_BRD   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_hdr r_mem [ARENA_BYTES/4];
    t_hdr r_rd;
    logic [HW-1:0] w_ra;
    logic          w_we;
    logic [HW-1:0] w_wa;
    t_hdr          w_wd;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[w_ra];
    end

    t_state        r_st;
    logic [PW-1:0] r_lim, r_pages;
    logic          r_exist;
    logic [AW-1:0] r_head, r_cur, r_last, r_blk;
    logic [AW:0]   r_need;
    t_hdr          r_bh;
    t_rsp          r_rsp;
    logic [AW:0]   w_sum;
    logic [PW-1:0] w_bud;
    logic          w_can_grow;
    logic [AW-1:0] w_base;
    logic [AW+1:0] w_pend;
    logic [AW-1:0] w_blk;

    assign w_bud      = (r_lim > PW'(MAX_PAGES)) ? PW'(MAX_PAGES) : r_lim;
    assign w_can_grow = r_pages < w_bud;
    assign w_base     = AW'(r_pages) * AW'(PAGE_BYTES);
    assign w_pend     = (AW+2)'(r_pages) * (AW+2)'(PAGE_BYTES);
    assign w_sum      = {1'b0, r_rd.size} - r_need;
    assign w_blk      = i_req.block_address - AW'(HEADER_BYTES);

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_rsp   = r_rsp;

    logic          w_fit, w_split;
    logic [AW-1:0] w_tail;
    assign w_fit   = r_rd.free && ({1'b0, r_rd.size} >= r_need);
    assign w_split = (w_sum >= (AW+1)'(HEADER_BYTES + 4));
    assign w_tail  = r_cur + AW'(HEADER_BYTES) + r_need[AW-1:0];

    always_comb begin
        w_ra = r_cur[AW-1:2];
        w_we = 1'b0;
        w_wa = r_cur[AW-1:2];
        w_wd = r_rd;
        if (r_st == S_IDLE) begin
            w_ra = w_blk[AW-1:2];
        end
        if (r_st == S_AEV && w_fit) begin
            w_we = 1'b1;
            w_wd.free = 1'b0;
            if (w_split) begin
                w_wd.size = r_need[AW-1:0];
                w_wd.link = 1'b1;
                w_wd.next = w_tail;
            end
        end else if (r_st == S_GROW) begin
            w_we = w_can_grow && r_exist;
            w_wa = r_last[AW-1:2];
            w_wd.link = 1'b1;
            w_wd.next = w_base;
        end else if (r_st == S_BRD) begin
            w_we = 1'b1;
            w_wa = r_cur[AW-1:2];
            w_wd = r_bh;
        end else if (r_st == S_FEV) begin
            w_we = 1'b1;
            w_wa = r_blk[AW-1:2];
            w_wd = r_bh;
        end else if (r_st == S_PEV && r_need == '1 && r_rd.link
                     && r_rd.next == r_blk && r_rd.free) begin
            w_we = 1'b1;
            w_wd.size = r_rd.size + AW'(HEADER_BYTES) + r_bh.size;
            w_wd.link = r_bh.link;
            w_wd.next = r_bh.next;
        end
    end

    // split tail write needs a second port write: stage it in S_BRD
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_lim   <= PW'(MAX_PAGES);
            r_pages <= '0;
            r_exist <= 1'b0;
            r_head  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_lim <= i_cfg_wdata;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_need <= ({1'b0, i_req.request_size} + (AW+1)'(3))
                                  & ~(AW+1)'(3);
                        r_rsp  <= '{result_address: '0, status: ST_FREE};
                        if (i_req.req_type == RT_ALLOC) begin
                            if (r_exist) begin
                                r_cur  <= r_head;
                                r_last <= r_head;
                                r_st   <= S_ARD;
                            end else begin
                                r_last <= '0;
                                r_st   <= S_GROW;
                            end
                        end else if (i_req.address_is_null
                                || i_req.block_address < AW'(HEADER_BYTES)
                                || {2'b0, i_req.block_address - AW'(HEADER_BYTES)}
                                   >= w_pend) begin
                            r_st <= S_OUT;
                        end else begin
                            r_blk <= i_req.block_address - AW'(HEADER_BYTES);
                            r_cur <= i_req.block_address - AW'(HEADER_BYTES);
                            r_st  <= S_FRD;
                        end
                    end
                end
                S_ARD: r_st <= S_AEV;
                S_AEV: begin
                    if (w_fit) begin
                        r_rsp <= '{result_address: r_cur + AW'(HEADER_BYTES),
                                   status: ST_ALLOC};
                        if (w_split) begin
                            r_bh.size <= AW'(w_sum) - AW'(HEADER_BYTES);
                            r_bh.free <= 1'b1;
                            r_bh.link <= r_rd.link;
                            r_bh.next <= r_rd.next;
                            r_cur     <= w_tail;
                            r_st      <= S_BRD;
                        end else begin
                            r_st <= S_OUT;
                        end
                    end else begin
                        r_last <= r_cur;
                        if (r_rd.link) begin
                            r_cur <= r_rd.next;
                            r_st  <= S_ARD;
                        end else begin
                            r_st <= S_GROW;
                        end
                    end
                end
                S_GROW: begin
                    if (!w_can_grow) begin
                        r_rsp <= '{result_address: '0, status: ST_FAIL};
                        r_st  <= S_OUT;
                    end else begin
                        r_pages <= r_pages + PW'(1);
                        if (!r_exist) begin
                            r_exist <= 1'b1;
                            r_head  <= w_base;
                        end
                        r_bh  <= '{size: AW'(PAGE_BYTES - HEADER_BYTES), free: 1'b1,
                                   link: 1'b0, next: '0};
                        r_cur <= w_base;
                        r_st  <= S_BRD;
                    end
                end
                S_BRD: begin
                    if (r_rsp.status == ST_ALLOC) begin
                        r_st <= S_OUT;
                    end else begin
                        r_last <= r_cur;
                        r_st   <= S_ARD;
                    end
                end
                S_FRD: begin
                    r_bh <= '{size: r_rd.size, free: 1'b1,
                              link: r_rd.link, next: r_rd.next};
                    r_st <= S_FEV;
                end
                S_FEV: begin
                    if (r_bh.link) begin
                        r_cur <= r_bh.next;
                        r_st  <= S_PRD;
                    end else begin
                        r_cur <= r_head;
                        r_st  <= r_exist ? S_PRD : S_OUT;
                        r_need <= '1;
                    end
                end
                S_PRD: r_st <= S_PEV;
                S_PEV: begin
                    if (r_need != '1) begin
                        if (r_rd.free) begin
                            r_bh.size <= r_bh.size + AW'(HEADER_BYTES) + r_rd.size;
                            r_bh.link <= r_rd.link;
                            r_bh.next <= r_rd.next;
                            r_st      <= S_FEV;
                        end else begin
                            r_cur  <= r_head;
                            r_need <= '1;
                            r_st   <= S_PRD;
                        end
                    end else if (!r_rd.link || r_rd.next == r_blk) begin
                        r_st <= S_OUT;
                    end else begin
                        r_cur <= r_rd.next;
                        r_st  <= S_PRD;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
